FILE: design/sorted_table_ceil_search_defines.svh
// ----------------------------------------------------------------------------
// sorted table ceiling search: assertion macros
// shared property shapes, clocked on clk and held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_CEIL_SEARCH_DEFINES_SVH
`define SORTED_TABLE_CEIL_SEARCH_DEFINES_SVH

// condition must hold on every enabled edge
`define STCS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define STCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/stcs_pkg.sv
// ----------------------------------------------------------------------------
// stcs_pkg
// shared constants and types of the sorted table ceiling search
// ----------------------------------------------------------------------------
package stcs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int ACT_W       = 2;
  localparam int POS_W       = 10;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_QUERY  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } seq_state_t;

  // query start request toward the sequencer
  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] key;
    logic [CNT_W-1:0]         count;
  } seq_cmd_t;

  // sequencer status and result
  typedef struct packed {
    logic             busy;
    logic             done;
    logic             found;
    logic [IDX_W-1:0] idx;
  } seq_status_t;

  // one search step
  typedef struct packed {
    logic             gt;
    logic [CNT_W-1:0] lo_n;
    logic [CNT_W-1:0] hi_n;
    logic             more;
    logic [IDX_W-1:0] mid_n;
  } step_t;

endpackage

FILE: design/stcs_in_if.sv
// ----------------------------------------------------------------------------
// stcs_in_if
// input channel: action and value with valid/ready
// ----------------------------------------------------------------------------
interface stcs_in_if
  import stcs_pkg::*;
();

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);

endinterface

FILE: design/stcs_out_if.sv
// ----------------------------------------------------------------------------
// stcs_out_if
// result channel: found, position and full_error with valid/ready
// ----------------------------------------------------------------------------
interface stcs_out_if
  import stcs_pkg::*;
();

  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] position;
  logic             full_error;

  modport source (output valid, output found, output position, output full_error,
                  input ready);
  modport sink   (input valid, input found, input position, input full_error,
                  output ready);

endinterface

FILE: design/sorted_table_ceil_search.sv
// ----------------------------------------------------------------------------
// sorted_table_ceil_search
// table of signed values with clear, append and ceiling query
// ----------------------------------------------------------------------------
// Clear, append and unused action codes complete in the cycle they are
// accepted, so one such item can be taken every cycle while the result side
// keeps up. A query over a table of n entries runs one probe per cycle, each
// probe being a table read whose registered data feeds the compare that picks
// the next read address: floor(log2(n)) + 1 probes at most, after a launch
// step that loads the first read address and before a done step that hands
// the result to the output register. An empty table answers at once. The
// input is not ready while a query is in flight or the output register holds
// a result that is not being taken.
`include "sorted_table_ceil_search_defines.svh"

module sorted_table_ceil_search
  import stcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  stcs_in_if.sink     in_ch,
  stcs_out_if.source  out_ch
);

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              found_r, found_nxt;
  logic [POS_W-1:0]  position_r, position_nxt;
  logic              full_err_r, full_err_nxt;

  logic              out_free;
  logic              in_xfer;
  logic              is_query;
  logic              is_append;
  logic              tbl_full;
  logic              wr_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_data;
  seq_cmd_t          cmd;
  seq_status_t       status;
  logic              take;

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !status.busy && out_free;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign is_query     = in_ch.action == ACT_QUERY;
  assign is_append    = in_ch.action == ACT_APPEND;
  assign tbl_full     = cnt_r >= CNT_W'(TABLE_DEPTH);
  assign wr_en        = in_xfer && is_append && !tbl_full;
  assign take         = status.done && out_free;

  assign cmd.start = in_xfer && is_query && (cnt_r != '0);
  assign cmd.key   = in_ch.value;
  assign cmd.count = cnt_r;

  stcs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IDX_W'(cnt_r)),
    .wdata (in_ch.value),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  stcs_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .take    (take),
    .rd_data (rd_data),
    .rd_addr (rd_addr),
    .status  (status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r    <= found_nxt;
    position_r <= position_nxt;
    full_err_r <= full_err_nxt;
  end

  always_comb begin
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    found_nxt     = found_r;
    position_nxt  = position_r;
    full_err_nxt  = full_err_r;
    if (in_xfer) begin
      unique case (in_ch.action)
        ACT_CLEAR:  cnt_nxt = '0;
        ACT_APPEND: begin
          if (!tbl_full) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        ACT_QUERY:  cnt_nxt = cnt_r;
        default:    cnt_nxt = cnt_r;
      endcase
      // every transfer but a query on a non-empty table answers right away
      if (!cmd.start) begin
        out_valid_nxt = 1'b1;
        found_nxt     = 1'b0;
        position_nxt  = '0;
        full_err_nxt  = is_append && tbl_full;
      end
    end else if (take) begin
      out_valid_nxt = 1'b1;
      found_nxt     = status.found;
      position_nxt  = status.found ? POS_W'(status.idx) : '0;
      full_err_nxt  = 1'b0;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.found      = found_r;
  assign out_ch.position   = position_r;
  assign out_ch.full_error = full_err_r;

  `STCS_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CNT_W'(TABLE_DEPTH), "fill count beyond depth")
  `STCS_ASSERT_IMPL(a_no_write_busy, wr_en, !status.busy, "table write during search")
  `STCS_ASSERT_NEXT(a_out_hold, out_valid_r && !out_ch.ready,
                    out_valid_r && $stable(found_r) && $stable(position_r) && $stable(full_err_r),
                    "result changed while stalled")

endmodule

FILE: design/stcs_ram.sv
// ----------------------------------------------------------------------------
// stcs_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module stcs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/stcs_probe.sv
// ----------------------------------------------------------------------------
// stcs_probe
// one binary search step: compare probed entry, narrow range, next probe
// ----------------------------------------------------------------------------
module stcs_probe
  import stcs_pkg::*;
(
  input  logic [CNT_W-1:0]         lo,
  input  logic [CNT_W-1:0]         hi,
  input  logic [IDX_W-1:0]         mid,
  input  logic signed [DATA_W-1:0] rd_data,
  input  logic signed [DATA_W-1:0] key,
  output step_t                    step
);

  logic [CNT_W-1:0] mid_ext;
  logic [CNT_W-1:0] span;

  always_comb begin
    mid_ext   = CNT_W'(mid);
    step.gt   = rd_data > key;
    // hi is exclusive: greater entry closes the range at mid
    if (step.gt) begin
      step.lo_n = lo;
      step.hi_n = mid_ext;
    end else begin
      step.lo_n = mid_ext + CNT_W'(1);
      step.hi_n = hi;
    end
    step.more  = step.lo_n < step.hi_n;
    span       = step.hi_n - step.lo_n - CNT_W'(1);
    step.mid_n = IDX_W'(step.lo_n + (span >> 1));
  end

endmodule

FILE: design/stcs_seq.sv
// ----------------------------------------------------------------------------
// stcs_seq
// search sequencer: drives the table read port and a single probe unit used for every step
// ----------------------------------------------------------------------------
`include "sorted_table_ceil_search_defines.svh"

module stcs_seq
  import stcs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  seq_cmd_t                 cmd,
  input  logic                     take,
  input  logic signed [DATA_W-1:0] rd_data,
  output logic [IDX_W-1:0]         rd_addr,
  output seq_status_t              status
);

  seq_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]         lo_r, lo_nxt;
  logic [CNT_W-1:0]         hi_r, hi_nxt;
  logic [IDX_W-1:0]         mid_r, mid_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic                     found_r, found_nxt;
  logic [IDX_W-1:0]         ans_r, ans_nxt;
  step_t                    step;

  stcs_probe u_probe (
    .lo      (lo_r),
    .hi      (hi_r),
    .mid     (mid_r),
    .rd_data (rd_data),
    .key     (key_r),
    .step    (step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    key_r   <= key_nxt;
    found_r <= found_nxt;
    ans_r   <= ans_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    key_nxt   = key_r;
    found_nxt = found_r;
    ans_nxt   = ans_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.start) begin
          lo_nxt    = '0;
          hi_nxt    = cmd.count;
          mid_nxt   = IDX_W'((cmd.count - CNT_W'(1)) >> 1);
          key_nxt   = cmd.key;
          found_nxt = 1'b0;
          ans_nxt   = '0;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        lo_nxt  = step.lo_n;
        hi_nxt  = step.hi_n;
        mid_nxt = step.mid_n;
        if (step.gt) begin
          found_nxt = 1'b1;
          ans_nxt   = mid_r;
        end
        if (!step.more) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign rd_addr      = mid_nxt;
  assign status.busy  = state_r != ST_IDLE;
  assign status.done  = state_r == ST_DONE;
  assign status.found = found_r;
  assign status.idx   = ans_r;

  `STCS_ASSERT_IMPL(a_range_open, state_r == ST_SEARCH, lo_r < hi_r, "search with empty range")
  `STCS_ASSERT_IMPL(a_probe_inside, state_r == ST_SEARCH,
                    (CNT_W'(mid_r) >= lo_r) && (CNT_W'(mid_r) < hi_r), "probe outside range")
  `STCS_ASSERT_IMPL(a_start_idle, cmd.start, state_r == ST_IDLE, "start while busy")
  `STCS_ASSERT_NEXT(a_take_idle, (state_r == ST_DONE) && take, state_r == ST_IDLE,
                    "result taken but not idle")

endmodule
